/* design/elp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// elp_pkg
// Shared types and constants of the ASCII expression line parser.
// ----------------------------------------------------------------------------
package elp_pkg;

	localparam int LINE_LEN = 20;
	localparam int CNT_W    = $clog2(LINE_LEN);
	localparam int MAG_W    = 57;
	localparam int VAL_W    = 58;
	localparam int Q_DEPTH  = 4;
	localparam int Q_AW     = $clog2(Q_DEPTH);
	localparam int OUT_W    = 3 + 2 * VAL_W;
	localparam int OUT_BW   = ((OUT_W + 7) / 8) * 8;

	// Token kinds passed from the front to the back.
	localparam logic [1:0] TOK_CHAR = 2'd0;
	localparam logic [1:0] TOK_END  = 2'd1;
	localparam logic [1:0] TOK_OVF  = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_CMD     = 2'd0;
	localparam logic [1:0] KIND_INVALID = 2'd1;
	localparam logic [1:0] KIND_DIV0    = 2'd2;
	localparam logic [1:0] KIND_LONG    = 2'd3;

	// Operator codes.
	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_SUB    = 3'd1;
	localparam logic [2:0] OP_MUL    = 3'd2;
	localparam logic [2:0] OP_DIV    = 3'd3;
	localparam logic [2:0] OP_MATMUL = 3'd4;

	// Characters.
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_Z_LO  = 8'h7A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [1:0] kind;
		logic       is_digit;
		logic       is_space;
		logic       is_minus;
		logic       is_op;
		logic [2:0] op;
		logic [3:0] digit;
	} tok_t;

endpackage
`default_nettype wire

/* design/elp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// elp_front
// Counts line fill, detects overflow and line ends, and classifies characters.
// ----------------------------------------------------------------------------
module elp_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic [7:0]   in_byte,
	input  wire logic         q_full,
	output logic              in_ready,
	output logic              q_wr,
	output elp_pkg::tok_t     q_data
);

	logic [elp_pkg::CNT_W-1:0] fill_q;
	logic                      take;
	logic                      full_line;
	logic                      line_end;

	assign in_ready  = !q_full;
	assign take      = in_valid && !q_full;
	assign q_wr      = take;
	assign full_line = (fill_q == elp_pkg::CNT_W'(elp_pkg::LINE_LEN - 1));
	assign line_end  = (in_byte == elp_pkg::CH_CR) || (in_byte == elp_pkg::CH_LF);

	always_comb begin
		q_data          = '0;
		q_data.is_digit = (in_byte >= elp_pkg::CH_ZERO) && (in_byte <= elp_pkg::CH_NINE);
		q_data.is_space = (in_byte == elp_pkg::CH_SPACE);
		q_data.is_minus = (in_byte == elp_pkg::CH_MINUS);
		q_data.is_op    = (in_byte == elp_pkg::CH_PLUS) || (in_byte == elp_pkg::CH_MINUS) ||
			(in_byte == elp_pkg::CH_SLASH) || (in_byte == elp_pkg::CH_X_LO) ||
			(in_byte == elp_pkg::CH_X_UP) || (in_byte == elp_pkg::CH_STAR) ||
			(in_byte == elp_pkg::CH_Z_LO);
		q_data.digit    = in_byte[3:0];
		case (in_byte)
			elp_pkg::CH_PLUS:  q_data.op = elp_pkg::OP_ADD;
			elp_pkg::CH_MINUS: q_data.op = elp_pkg::OP_SUB;
			elp_pkg::CH_SLASH: q_data.op = elp_pkg::OP_DIV;
			elp_pkg::CH_Z_LO:  q_data.op = elp_pkg::OP_MATMUL;
			default:           q_data.op = elp_pkg::OP_MUL;
		endcase
		// A full buffer wins over a line end in the same character.
		if (full_line) begin
			q_data.kind = elp_pkg::TOK_OVF;
		end else if (line_end) begin
			q_data.kind = elp_pkg::TOK_END;
		end else begin
			q_data.kind = elp_pkg::TOK_CHAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (take) begin
			if (full_line || line_end) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/elp_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// elp_fifo
// Short token queue between the front and the back.
// ----------------------------------------------------------------------------
module elp_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  elp_pkg::tok_t      wr_data,
	output logic               full,
	output logic               rd_valid,
	output elp_pkg::tok_t      rd_data,
	input  wire logic          rd_take
);

	elp_pkg::tok_t             mem_q [elp_pkg::Q_DEPTH];
	logic [elp_pkg::Q_AW-1:0]  wp_q;
	logic [elp_pkg::Q_AW-1:0]  rp_q;
	logic [elp_pkg::Q_AW:0]    cnt_q;
	logic                      do_rd;

	assign full     = (cnt_q == (elp_pkg::Q_AW + 1)'(elp_pkg::Q_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign do_rd    = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr && do_rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/elp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// elp_back
// Parses the token stream into operands and operator and holds the result.
// ----------------------------------------------------------------------------
module elp_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         tok_valid,
	input  elp_pkg::tok_t                     tok,
	output logic                              tok_take,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        out_kind,
	output logic [2:0]                        out_op,
	output logic [elp_pkg::VAL_W-1:0]         out_first,
	output logic [elp_pkg::VAL_W-1:0]         out_second
);

	// Operand scan states.
	localparam logic [2:0] OPD_LEAD  = 3'd0;
	localparam logic [2:0] OPD_SIGN  = 3'd1;
	localparam logic [2:0] OPD_DIG   = 3'd2;
	localparam logic [2:0] OPD_TRAIL = 3'd3;
	localparam logic [2:0] OPD_BAD   = 3'd4;

	localparam int MAG_W = elp_pkg::MAG_W;

	function automatic logic [2:0] opd_next(input logic [2:0] st, input elp_pkg::tok_t t);
		logic [2:0] nx;
		nx = OPD_BAD;
		case (st)
			OPD_LEAD: begin
				if (t.is_space) nx = OPD_LEAD;
				else if (t.is_minus) nx = OPD_SIGN;
				else if (t.is_digit) nx = OPD_DIG;
			end
			OPD_SIGN, OPD_DIG: begin
				if (t.is_digit) nx = OPD_DIG;
				else if (t.is_space) nx = OPD_TRAIL;
			end
			OPD_TRAIL: begin
				if (t.is_space) nx = OPD_TRAIL;
			end
			default: nx = OPD_BAD;
		endcase
		return nx;
	endfunction

	// Saturating mag * 10 + d; the sum never reaches 2^61.
	function automatic logic [MAG_W-1:0] mag_next(input logic [MAG_W-1:0] m,
		input logic [3:0] d);
		logic [MAG_W+3:0] s;
		s = {1'b0, m, 3'b000} + {3'b000, m, 1'b0} + {{MAG_W{1'b0}}, d};
		if (s[MAG_W+3:MAG_W] != '0) begin
			return '1;
		end
		return s[MAG_W-1:0];
	endfunction

	logic [2:0]        a_st_q, b_st_q, a_st_d, b_st_d;
	logic [MAG_W-1:0]  a_mag_q, b_mag_q;
	logic              a_neg_q, b_neg_q;
	logic              phase_b_q;
	logic              seen_dig_q;
	logic [2:0]        op_q;
	logic              ovf_rep_q;
	logic              emit;
	logic              to_b;
	logic [1:0]        res_kind;
	logic [elp_pkg::VAL_W-1:0] a_val, b_val;

	assign tok_take = tok_valid && (!out_valid || out_ready);
	assign to_b     = !phase_b_q && seen_dig_q && tok.is_op;
	assign a_st_d   = opd_next(a_st_q, tok);
	assign b_st_d   = opd_next(b_st_q, tok);
	assign a_val    = a_neg_q ? (-{1'b0, a_mag_q}) : {1'b0, a_mag_q};
	assign b_val    = b_neg_q ? (-{1'b0, b_mag_q}) : {1'b0, b_mag_q};

	always_comb begin
		emit     = 1'b0;
		res_kind = elp_pkg::KIND_CMD;
		case (tok.kind)
			elp_pkg::TOK_OVF: begin
				emit     = !ovf_rep_q;
				res_kind = elp_pkg::KIND_LONG;
			end
			elp_pkg::TOK_END: begin
				emit = 1'b1;
				if (!phase_b_q || a_st_q == OPD_BAD || b_st_q == OPD_BAD) begin
					res_kind = elp_pkg::KIND_INVALID;
				end else if (op_q == elp_pkg::OP_DIV && b_mag_q == '0) begin
					res_kind = elp_pkg::KIND_DIV0;
				end else begin
					res_kind = elp_pkg::KIND_CMD;
				end
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_st_q     <= OPD_LEAD;
			b_st_q     <= OPD_LEAD;
			a_mag_q    <= '0;
			b_mag_q    <= '0;
			a_neg_q    <= 1'b0;
			b_neg_q    <= 1'b0;
			phase_b_q  <= 1'b0;
			seen_dig_q <= 1'b0;
			op_q       <= elp_pkg::OP_ADD;
			ovf_rep_q  <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (tok_take && emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (tok_take) begin
				if (tok.kind == elp_pkg::TOK_CHAR) begin
					if (to_b) begin
						phase_b_q <= 1'b1;
						op_q      <= tok.op;
					end else if (!phase_b_q) begin
						a_st_q     <= a_st_d;
						seen_dig_q <= seen_dig_q || tok.is_digit;
						if (a_st_q == OPD_LEAD && tok.is_minus) a_neg_q <= 1'b1;
						if (a_st_d == OPD_DIG) a_mag_q <= mag_next(a_mag_q, tok.digit);
					end else begin
						b_st_q <= b_st_d;
						if (b_st_q == OPD_LEAD && tok.is_minus) b_neg_q <= 1'b1;
						if (b_st_d == OPD_DIG) b_mag_q <= mag_next(b_mag_q, tok.digit);
					end
				end else begin
					// Any line end or overflow starts a new line.
					a_st_q     <= OPD_LEAD;
					b_st_q     <= OPD_LEAD;
					a_mag_q    <= '0;
					b_mag_q    <= '0;
					a_neg_q    <= 1'b0;
					b_neg_q    <= 1'b0;
					phase_b_q  <= 1'b0;
					seen_dig_q <= 1'b0;
					op_q       <= elp_pkg::OP_ADD;
					ovf_rep_q  <= (tok.kind == elp_pkg::TOK_OVF);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_take && emit) begin
			out_kind <= res_kind;
			if (res_kind == elp_pkg::KIND_CMD) begin
				out_op     <= op_q;
				out_first  <= a_val;
				out_second <= b_val;
			end else begin
				out_op     <= elp_pkg::OP_ADD;
				out_first  <= '0;
				out_second <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != elp_pkg::KIND_CMD |->
		out_op == elp_pkg::OP_ADD && out_first == '0 && out_second == '0)
		else $error("error result carries nonzero payload");
	a_end_clr: assert property (@(posedge clk) disable iff (!arst_n)
		tok_take && tok.kind == elp_pkg::TOK_END |=> !ovf_rep_q)
		else $error("line end did not clear overflow flag");
	a_ovf_set: assert property (@(posedge clk) disable iff (!arst_n)
		tok_take && tok.kind == elp_pkg::TOK_OVF |=> ovf_rep_q)
		else $error("overflow did not set flag");
	a_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_b_q |-> seen_dig_q)
		else $error("operator taken before any digit");
`endif

endmodule
`default_nettype wire

/* design/ascii_expression_line_parser_top.sv */
`default_nettype none
// A line end or first overflow byte is queued, and the back registers m_tvalid as it takes the token.
// Throughput: one byte per cycle while m_tready is high; the back takes one token per cycle.
// A stalled output holds the back, and the four-entry token queue then fills before s_tready drops.
// Reset (arst_n low) clears the fill count, queue, parse state and overflow flag at once.
// ----------------------------------------------------------------------------
// ascii_expression_line_parser_top
// Parses received ASCII command lines into an operator and two signed operands.
// ----------------------------------------------------------------------------
module ascii_expression_line_parser_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,  // rx_byte
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [elp_pkg::OUT_BW-1:0]       m_tdata,  // op_code, first_value, second_value
	output logic [1:0]                       m_tuser   // kind
);

	elp_pkg::tok_t              f_data;
	elp_pkg::tok_t              q_data;
	logic                       f_wr;
	logic                       q_full;
	logic                       q_valid;
	logic                       q_take;
	logic [1:0]                 kind;
	logic [2:0]                 op_code;
	logic [elp_pkg::VAL_W-1:0]  first_value;
	logic [elp_pkg::VAL_W-1:0]  second_value;

	elp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.q_full   (q_full),
		.in_ready (s_tready),
		.q_wr     (f_wr),
		.q_data   (f_data)
	);

	elp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (f_wr),
		.wr_data  (f_data),
		.full     (q_full),
		.rd_valid (q_valid),
		.rd_data  (q_data),
		.rd_take  (q_take)
	);

	elp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tok_valid  (q_valid),
		.tok        (q_data),
		.tok_take   (q_take),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (kind),
		.out_op     (op_code),
		.out_first  (first_value),
		.out_second (second_value)
	);

	assign m_tdata = {{(elp_pkg::OUT_BW - elp_pkg::OUT_W){1'b0}},
		second_value, first_value, op_code};
	assign m_tuser = kind;

endmodule
`default_nettype wire
